@@ hw/rtl/weather_sensor_frame_transmitter_assert.svh @@
// assertion macros used by the transmitter engine
`ifndef WEATHER_SENSOR_FRAME_TRANSMITTER_ASSERT_SVH
`define WEATHER_SENSOR_FRAME_TRANSMITTER_ASSERT_SVH

// condition and consequence in the same cycle
`define WSFT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequence in the cycle after the condition
`define WSFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/wsft_pkg.sv @@
package wsft_pkg;

    // input item as seen on the port
    typedef struct packed {
        logic              operation;
        logic              battery_ok;
        logic signed [7:0] temperature;
        logic        [6:0] humidity;
    } t_in_item;

    // result item
    typedef struct packed {
        logic tx_level;
        logic power_on;
        logic busy_res;
        logic start_rejected;
    } t_res_item;

    // classified command passed from the front to the back
    typedef struct packed {
        logic       is_start;
        logic [3:0] batt_nibble;
        logic [7:0] temp_bcd;
        logic       temp_neg;
        logic [7:0] hum_bcd;
    } t_cmd;

    // configuration registers
    typedef struct packed {
        logic [7:0] sensor_id;
        logic [3:0] channel_number;
        logic [7:0] warmup_ticks;
        logic [7:0] repeat_gap_ticks;
    } t_cfg;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WARMUP,
        MODE_SEND,
        MODE_GAP
    } t_mode;

    // register indexes
    localparam logic [1:0] CFG_SENSOR_ID      = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_NUMBER = 2'd1;
    localparam logic [1:0] CFG_WARMUP_TICKS   = 2'd2;
    localparam logic [1:0] CFG_REPEAT_GAP     = 2'd3;

    // frame layout
    localparam int         FRAME_BYTES    = 12;
    localparam logic [6:0] FRAME_LAST_BIT = 7'd95;
    localparam logic [7:0] PREAMBLE_BYTE  = 8'hff;
    localparam logic [7:0] DEVICE_BYTE_A  = 8'h1a;
    localparam logic [7:0] DEVICE_BYTE_B  = 8'h2d;
    localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;
    localparam logic [3:0] BATT_OK_NIB    = 4'h1;
    localparam logic [3:0] BATT_LOW_NIB   = 4'hc;
    localparam logic [3:0] SIGN_NEG_NIB   = 4'h8;
    // device nibbles 1+a+2+d less the skipped first nibble a
    localparam logic [7:0] CHECKSUM_BIAS  = 8'd16;

endpackage

@@ hw/rtl/wsft_front.sv @@
module wsft_front
    import wsft_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_ready,
    output logic     o_push,
    output t_cmd     o_cmd
);

    // saturate to 99 and split into two bcd digits
    function automatic logic [7:0] to_bcd99(input logic [7:0] v);
        logic [6:0]  sat;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        sat   = (v > 8'd99) ? 7'd99 : v[6:0];
        prod  = 15'(sat) * 15'd205;
        tens  = prod[14:11];
        units = sat - 7'(tens) * 7'd10;
        return {tens, units[3:0]};
    endfunction

    logic       w_neg;
    logic [7:0] w_mag;

    // magnitude of the signed temperature
    assign w_neg = i_in_item.temperature[7];
    assign w_mag = w_neg ? (8'd0 - 8'(i_in_item.temperature)) : 8'(i_in_item.temperature);

    // classify the item and pre-format the sensor digits
    always_comb begin
        o_cmd.is_start    = i_in_item.operation;
        o_cmd.batt_nibble = i_in_item.battery_ok ? BATT_OK_NIB : BATT_LOW_NIB;
        o_cmd.temp_bcd    = to_bcd99(w_mag);
        o_cmd.temp_neg    = w_neg;
        o_cmd.hum_bcd     = to_bcd99({1'b0, i_in_item.humidity});
    end

    // handshake with the queue
    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid & i_q_ready;

endmodule

@@ hw/rtl/wsft_queue.sv @@
module wsft_queue
    import wsft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

endmodule

@@ hw/rtl/wsft_engine.sv @@
`include "weather_sensor_frame_transmitter_assert.svh"

module wsft_engine
    import wsft_pkg::*;
#(
    parameter int REPEAT_COUNT = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_res_item o_out_item
);

    localparam int RW = (REPEAT_COUNT > 1) ? $clog2(REPEAT_COUNT) : 1;

    t_mode      r_mode, n_mode;
    logic [6:0] r_bit_index, n_bit_index;
    logic [1:0] r_bit_phase, n_bit_phase;
    logic [7:0] r_wait, n_wait;
    logic [RW-1:0] r_rep, n_rep;
    logic [7:0] r_frame [FRAME_BYTES];
    logic       r_out_valid;
    t_res_item  r_res;
    t_res_item  w_res;
    logic       w_fire;
    logic       w_build;
    logic       w_bit;
    logic [7:0] w_sum;

    // take a command when the output register is free or draining
    assign w_fire = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_fire;

    // current frame bit, lsb first
    assign w_bit = r_frame[r_bit_index[6:3]][r_bit_index[2:0]];

    // nibble checksum over device type to humidity tens
    assign w_sum = CHECKSUM_BIAS + 8'(i_cfg.channel_number)
                 + 8'(i_cfg.sensor_id[7:4]) + 8'(i_cfg.sensor_id[3:0])
                 + 8'(i_cmd.batt_nibble)
                 + 8'(i_cmd.temp_bcd[7:4]) + 8'(i_cmd.temp_bcd[3:0])
                 + (i_cmd.temp_neg ? 8'(SIGN_NEG_NIB) : 8'd0)
                 + 8'(i_cmd.hum_bcd[7:4]) + 8'(i_cmd.hum_bcd[3:0]);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_bit_index <= '0;
            r_bit_phase <= '0;
            r_wait      <= '0;
            r_rep       <= '0;
        end else begin
            r_mode      <= n_mode;
            r_bit_index <= n_bit_index;
            r_bit_phase <= n_bit_phase;
            r_wait      <= n_wait;
            r_rep       <= n_rep;
        end
    end

    // sequencer: next state and result for one command
    always_comb begin
        n_mode      = r_mode;
        n_bit_index = r_bit_index;
        n_bit_phase = r_bit_phase;
        n_wait      = r_wait;
        n_rep       = r_rep;
        w_res       = '0;
        w_build     = 1'b0;
        if (w_fire) begin
            if (i_cmd.is_start) begin
                w_res.power_on = 1'b1;
                w_res.busy_res = 1'b1;
                if (r_mode != MODE_IDLE) begin
                    w_res.start_rejected = 1'b1;
                end else begin
                    w_build = 1'b1;
                    n_rep   = '0;
                    if (i_cfg.warmup_ticks != 8'd0) begin
                        n_wait = i_cfg.warmup_ticks;
                        n_mode = MODE_WARMUP;
                    end else begin
                        n_bit_index = '0;
                        n_bit_phase = '0;
                        n_mode      = MODE_SEND;
                    end
                end
            end else begin
                case (r_mode)
                    MODE_WARMUP, MODE_GAP: begin
                        w_res.power_on = 1'b1;
                        w_res.busy_res = 1'b1;
                        n_wait = r_wait - 8'd1;
                        if (r_wait == 8'd1) begin
                            n_bit_index = '0;
                            n_bit_phase = '0;
                            n_mode      = MODE_SEND;
                        end
                    end
                    MODE_SEND: begin
                        // one is low,high,high,low; zero the inverse
                        w_res.tx_level = w_bit ^ ((r_bit_phase == 2'd0) || (r_bit_phase == 2'd3));
                        w_res.power_on = 1'b1;
                        w_res.busy_res = 1'b1;
                        n_bit_phase = r_bit_phase + 2'd1;
                        if (r_bit_phase == 2'd3) begin
                            if (r_bit_index == FRAME_LAST_BIT) begin
                                n_bit_index = '0;
                                if ((RW+1)'(r_rep) + (RW+1)'(1) < (RW+1)'(REPEAT_COUNT)) begin
                                    n_rep = r_rep + RW'(1);
                                    if (i_cfg.repeat_gap_ticks != 8'd0) begin
                                        n_wait = i_cfg.repeat_gap_ticks;
                                        n_mode = MODE_GAP;
                                    end else begin
                                        n_bit_phase = '0;
                                        n_mode      = MODE_SEND;
                                    end
                                end else begin
                                    n_rep  = '0;
                                    n_mode = MODE_IDLE;
                                end
                            end else begin
                                n_bit_index = r_bit_index + 7'd1;
                            end
                        end
                    end
                    default: begin
                        // idle tick answers all zero
                    end
                endcase
            end
        end
    end

    // frame store, written whole on an accepted start
    always_ff @(posedge i_clk) begin
        if (w_build) begin
            r_frame[0]  <= PREAMBLE_BYTE;
            r_frame[1]  <= PREAMBLE_BYTE;
            r_frame[2]  <= DEVICE_BYTE_A;
            r_frame[3]  <= DEVICE_BYTE_B;
            r_frame[4]  <= {i_cfg.channel_number, 4'h0};
            r_frame[5]  <= i_cfg.sensor_id;
            r_frame[6]  <= {4'h0, i_cmd.batt_nibble};
            r_frame[7]  <= i_cmd.temp_bcd;
            r_frame[8]  <= {i_cmd.hum_bcd[3:0], (i_cmd.temp_neg ? SIGN_NEG_NIB : 4'h0)};
            r_frame[9]  <= {4'h0, i_cmd.hum_bcd[7:4]};
            r_frame[10] <= w_sum;
            r_frame[11] <= POSTAMBLE_BYTE;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) r_res <= w_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_res;

    // checks
    `WSFT_ASSERT_SAME(a_idle_at_origin, i_clk, i_rst_n, r_mode == MODE_IDLE, r_bit_index == '0 && r_bit_phase == '0)
    `WSFT_ASSERT_SAME(a_index_in_frame, i_clk, i_rst_n, 1'b1, r_bit_index <= FRAME_LAST_BIT)
    `WSFT_ASSERT_NEXT(a_reject_keeps_mode, i_clk, i_rst_n, w_fire && i_cmd.is_start && r_mode != MODE_IDLE, $stable(r_mode) && r_out_valid && r_res.start_rejected)

endmodule

@@ hw/rtl/weather_sensor_frame_transmitter.sv @@
// path: an accepted item's result passes the queue and then the output register
// throughput: one item per cycle while the consumer keeps taking results and the queue has room
// a two-entry queue decouples intake from the sequencer, output register from the consumer
// reset: synchronous active low; clears control state and loads register defaults
// the frame store is written whole by each accepted start, so no clearing pass follows reset
module weather_sensor_frame_transmitter
    import wsft_pkg::*;
#(
    parameter int REPEAT_COUNT = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_res_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_q_ready;
    logic w_push;
    t_cmd w_front_cmd;
    logic w_q_valid;
    logic w_pop;
    t_cmd w_q_cmd;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_id        <= 8'd0;
            r_cfg.channel_number   <= 4'd4;
            r_cfg.warmup_ticks     <= 8'd2;
            r_cfg.repeat_gap_ticks <= 8'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SENSOR_ID:      r_cfg.sensor_id        <= i_cfg_data;
                CFG_CHANNEL_NUMBER: r_cfg.channel_number   <= i_cfg_data[3:0];
                CFG_WARMUP_TICKS:   r_cfg.warmup_ticks     <= i_cfg_data;
                CFG_REPEAT_GAP:     r_cfg.repeat_gap_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // intake and classification
    wsft_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    // command queue
    wsft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    // frame sequencer
    wsft_engine #(
        .REPEAT_COUNT (REPEAT_COUNT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ verif/weather_sensor_frame_transmitter_test.sv @@
module weather_sensor_frame_transmitter_test
    import wsft_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CLK_PERIOD    = 8;
    localparam int   REPEATS       = 2;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   TAIL_ITEMS    = 24;
    localparam int   HOLD_AT_A     = 100;
    localparam int   HOLD_AT_B     = 400;
    localparam int   HOLD_CYCLES   = 40;
    localparam logic OP_TICK       = 1'b0;
    localparam logic OP_START      = 1'b1;

    // tracks the line waveform the transmitter should produce, one result per item
    class tx_waveform_check;
        logic [7:0] sensor_id;
        logic [3:0] channel;
        logic [7:0] warmup;
        logic [7:0] gap;
        t_mode      mode;
        logic [7:0] frame [FRAME_BYTES];
        logic [6:0] bit_pos;
        logic [1:0] quarter;
        logic [7:0] wait_left;
        int         copy_no;
        int         repeats;
        int         errors;
        t_res_item  levels_due [$];

        function new(int reps);
            repeats     = reps;
            sensor_id   = 8'd0;
            channel     = 4'd4;
            warmup      = 8'd2;
            gap         = 8'd16;
            mode        = MODE_IDLE;
            bit_pos     = '0;
            quarter     = '0;
            wait_left   = '0;
            copy_no     = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_SENSOR_ID:      sensor_id = data;
                CFG_CHANNEL_NUMBER: channel   = data[3:0];
                CFG_WARMUP_TICKS:   warmup    = data;
                CFG_REPEAT_GAP:     gap       = data;
                default: ;
            endcase
        endfunction

        function bit idle();
            return mode == MODE_IDLE;
        endfunction

        // two bcd digits, clipped at 99
        function logic [7:0] to_bcd(int v);
            if (v > 99) v = 99;
            return 8'(((v / 10) << 4) | (v % 10));
        endfunction

        function void latch_frame(t_in_item it);
            int         tv;
            int         mag;
            logic [7:0] hum_bcd;
            logic [7:0] sum;
            tv       = $signed(it.temperature);
            mag      = (tv < 0) ? -tv : tv;
            hum_bcd  = to_bcd(int'(it.humidity));
            frame[0] = PREAMBLE_BYTE;
            frame[1] = PREAMBLE_BYTE;
            frame[2] = DEVICE_BYTE_A;
            frame[3] = DEVICE_BYTE_B;
            frame[4] = {channel, 4'h0};
            frame[5] = sensor_id;
            frame[6] = {4'h0, it.battery_ok ? BATT_OK_NIB : BATT_LOW_NIB};
            frame[7] = to_bcd(mag);
            frame[8] = {hum_bcd[3:0], (tv < 0) ? SIGN_NEG_NIB : 4'h0};
            frame[9] = {4'h0, hum_bcd[7:4]};
            // nibble sum from device type to humidity tens, less the leading nibble
            sum = '0;
            for (int i = 2; i < 10; i++) begin
                sum = sum + 8'(frame[i][3:0]) + 8'(frame[i][7:4]);
            end
            frame[10] = sum - {4'h0, DEVICE_BYTE_A[3:0]};
            frame[11] = POSTAMBLE_BYTE;
        endfunction

        function void begin_copy();
            bit_pos = '0;
            quarter = '0;
            mode    = MODE_SEND;
        endfunction

        // advance by one accepted item and queue the result it causes
        function void note_item(t_in_item it);
            t_res_item res;
            logic      bit_val;
            logic      outer;
            res = '0;
            if (it.operation == OP_START) begin
                res.power_on = 1'b1;
                res.busy_res = 1'b1;
                if (mode != MODE_IDLE) begin
                    res.start_rejected = 1'b1;
                end else begin
                    latch_frame(it);
                    copy_no = 0;
                    if (warmup != 0) begin
                        wait_left = warmup;
                        mode      = MODE_WARMUP;
                    end else begin
                        begin_copy();
                    end
                end
            end else if (mode == MODE_WARMUP || mode == MODE_GAP) begin
                res.power_on = 1'b1;
                res.busy_res = 1'b1;
                wait_left    = wait_left - 1'b1;
                if (wait_left == 0) begin_copy();
            end else if (mode == MODE_SEND) begin
                // one is low,high,high,low; zero is the inverse
                bit_val      = frame[bit_pos[6:3]][bit_pos[2:0]];
                outer        = (quarter == 2'd0 || quarter == 2'd3);
                res.tx_level = bit_val ^ outer;
                res.power_on = 1'b1;
                res.busy_res = 1'b1;
                quarter      = quarter + 1'b1;
                if (quarter == 2'd0) begin
                    if (bit_pos == FRAME_LAST_BIT) begin
                        bit_pos = '0;
                        if (copy_no + 1 < repeats) begin
                            copy_no++;
                            if (gap != 0) begin
                                wait_left = gap;
                                mode      = MODE_GAP;
                            end else begin
                                begin_copy();
                            end
                        end else begin
                            copy_no = 0;
                            mode    = MODE_IDLE;
                        end
                    end else begin
                        bit_pos = bit_pos + 1'b1;
                    end
                end
            end
            levels_due.push_back(res);
        endfunction

        function void same_bit(string field, logic want, logic got);
            if (got !== want) begin
                $error("%s: expected %0b, got %0b", field, want, got);
                errors++;
            end
        endfunction

        function void check_item(t_res_item got);
            t_res_item want;
            if (levels_due.size() == 0) begin
                $error("result item with nothing pending: %b", got);
                errors++;
                return;
            end
            want = levels_due.pop_front();
            same_bit("tx_level", want.tx_level, got.tx_level);
            same_bit("power_on", want.power_on, got.power_on);
            same_bit("busy_res", want.busy_res, got.busy_res);
            same_bit("start_rejected", want.start_rejected, got.start_rejected);
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = CFG_SENSOR_ID;
    logic [7:0] cfg_data  = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_res_item  o_out_item;
    logic       o_cfg_ready;

    tx_waveform_check waveform;
    bit               quiet = 1'b0;

    weather_sensor_frame_transmitter #(
        .REPEAT_COUNT(REPEATS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int pause_draw();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic t_in_item random_item(logic op);
        t_in_item it;
        it.operation   = op;
        it.battery_ok  = 1'($urandom_range(0, 1));
        it.temperature = 8'($urandom_range(0, 255));
        it.humidity    = 7'($urandom_range(0, 127));
        return it;
    endfunction

    // offer one item after a random pause and wait for it to be taken
    task automatic send_item(t_in_item it);
        int pause;
        pause = pause_draw();
        if (pause > 0) begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!o_in_ready);
        waveform.note_item(it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        waveform.write_reg(idx, data);
    endtask

    task automatic program_regs(logic [7:0] id, logic [3:0] chan, logic [7:0] warm,
                                logic [7:0] gap);
        write_reg(CFG_SENSOR_ID, id);
        write_reg(CFG_CHANNEL_NUMBER, {4'h0, chan});
        write_reg(CFG_WARMUP_TICKS, warm);
        write_reg(CFG_REPEAT_GAP, gap);
        cfg_valid <= 1'b0;
    endtask

    // stop offering and let every pending result drain out
    task automatic settle();
        in_valid <= 1'b0;
        while (waveform.levels_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one whole transmission, with an idle tick first and a start while busy
    task automatic directed_frame(logic batt, logic [7:0] temp, logic [6:0] hum);
        t_in_item it;
        int       n;
        send_item(random_item(OP_TICK));
        it             = random_item(OP_START);
        it.battery_ok  = batt;
        it.temperature = temp;
        it.humidity    = hum;
        send_item(it);
        n = 0;
        while (!waveform.idle()) begin
            send_item(random_item((n == 5) ? OP_START : OP_TICK));
            n++;
        end
    endtask

    // result side: random stalls, a long hold-off at fixed result counts
    initial begin
        int stall;
        int taken;
        taken = 0;
        @(posedge clk iff rst_n);
        forever begin
            if (taken == HOLD_AT_A || taken == HOLD_AT_B) begin
                stall = HOLD_CYCLES + $urandom_range(0, 24);
            end else begin
                stall = pause_draw();
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!o_out_valid);
            waveform.check_item(o_out_item);
            taken++;
        end
    end

    // stimulus
    initial begin
        int   n;
        logic op;
        waveform = new(REPEATS);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, both saturations on a negative reading
        directed_frame(1'b0, 8'(-128), 7'd127);
        settle();

        // written registers, then a short back-to-back run with a fresh start
        program_regs(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), 8'd1, 8'd1);
        quiet = 1'b1;
        n     = 0;
        repeat (TAIL_ITEMS) begin
            op = (n % 4 == 1) ? OP_START : OP_TICK;
            send_item(random_item(op));
            n++;
        end

        settle();
        if (waveform.errors == 0) begin
            $display("weather_sensor_frame_transmitter test passed");
        end else begin
            $display("weather_sensor_frame_transmitter test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("weather_sensor_frame_transmitter test failed");
        $finish;
    end

endmodule
